[rtl/mhfd_pkg.sv]
package mhfd_pkg;

  localparam int AddrWidth = 4;
  localparam int DataWidth = 32;

  localparam logic [1:0] REG_MAGIC_WORD  = 2'd0;
  localparam logic [1:0] REG_VERSION     = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

  localparam logic [31:0] MAGIC_WORD_RESET  = 32'd0;
  localparam logic [7:0]  VERSION_RESET     = 8'd1;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1012;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ERR_BAD_MAGIC         = 2'd0;
  localparam logic [1:0] ERR_BAD_VERSION       = 2'd1;
  localparam logic [1:0] ERR_PAYLOAD_TOO_LARGE = 2'd2;
  localparam logic [1:0] ERR_NONE              = 2'd0;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [7:0]  protocol_version;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  frame_type;
    logic [15:0] sequence_res;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic [1:0]  error_code;
    logic        last;
  } result_t;

endpackage

[rtl/magic_header_frame_deframer_core.sv]
// Channel   Handshake              Payload
// input     in_valid / in_ready    rx_byte, restart
// output    out_valid / out_ready  kind, frame_type, sequence_res, payload_length,
//                                  data_byte, error_code, last
// config    APB psel/penable       paddr[3:0], pwdata, prdata
//
// One word is accepted every cycle the buffer is not full; any result is registered.
// The header and payload parser is a single registered pass per word.
// A two-entry output buffer keeps in_ready high while one result waits.
// Synchronous active-high reset returns the parser to hunting and restores registers.
module magic_header_frame_deframer_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      rx_byte,
  input  logic                            restart,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      kind,
  output logic [7:0]                      frame_type,
  output logic [15:0]                     sequence_res,
  output logic [15:0]                     payload_length,
  output logic [7:0]                      data_byte,
  output logic [1:0]                      error_code,
  output logic                            last,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mhfd_pkg::AddrWidth-1:0]  paddr,
  input  logic [mhfd_pkg::DataWidth-1:0]  pwdata,
  output logic [mhfd_pkg::DataWidth-1:0]  prdata,
  output logic                            pready
);

  mhfd_pkg::cfg_t    cfg;
  mhfd_pkg::result_t res;
  mhfd_pkg::result_t out_data;
  logic              res_valid;
  logic              take;

  assign take = in_valid && in_ready;

  mhfd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mhfd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx_byte),
    .restart   (restart),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  mhfd_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign kind           = out_data.kind;
  assign frame_type     = out_data.frame_type;
  assign sequence_res   = out_data.sequence_res;
  assign payload_length = out_data.payload_length;
  assign data_byte      = out_data.data_byte;
  assign error_code     = out_data.error_code;
  assign last           = out_data.last;

endmodule

[rtl/mhfd_regs.sv]
module mhfd_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mhfd_pkg::AddrWidth-1:0]  paddr,
  input  logic [mhfd_pkg::DataWidth-1:0]  pwdata,
  output logic [mhfd_pkg::DataWidth-1:0]  prdata,
  output logic                            pready,
  output mhfd_pkg::cfg_t                  cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_word       <= mhfd_pkg::MAGIC_WORD_RESET;
      cfg.protocol_version <= mhfd_pkg::VERSION_RESET;
      cfg.max_payload      <= mhfd_pkg::MAX_PAYLOAD_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        mhfd_pkg::REG_MAGIC_WORD:  cfg.magic_word       <= pwdata;
        mhfd_pkg::REG_VERSION:     cfg.protocol_version <= pwdata[7:0];
        mhfd_pkg::REG_MAX_PAYLOAD: cfg.max_payload      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      mhfd_pkg::REG_MAGIC_WORD:  prdata = cfg.magic_word;
      mhfd_pkg::REG_VERSION:     prdata = {24'd0, cfg.protocol_version};
      mhfd_pkg::REG_MAX_PAYLOAD: prdata = {16'd0, cfg.max_payload};
      default:                   prdata = '0;
    endcase
  end

endmodule

[rtl/mhfd_parse.sv]
module mhfd_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  input  logic                restart,
  input  mhfd_pkg::cfg_t      cfg,
  output logic                res_valid,
  output mhfd_pkg::result_t   res
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] magic_window, magic_window_next;
  logic [2:0]  window_fill, window_fill_next;
  logic [3:0]  header_count, header_count_next;
  logic [7:0]  header_version, header_version_next;
  logic [7:0]  header_type, header_type_next;
  logic [15:0] header_sequence, header_sequence_next;
  logic [31:0] header_length, header_length_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic        desync_flag, desync_flag_next;
  logic        emit;

  always_comb begin
    phase_next           = phase;
    magic_window_next    = magic_window;
    window_fill_next     = window_fill;
    header_count_next    = header_count;
    header_version_next  = header_version;
    header_type_next     = header_type;
    header_sequence_next = header_sequence;
    header_length_next   = header_length;
    bytes_remaining_next = bytes_remaining;
    desync_flag_next     = desync_flag;
    emit                 = 1'b0;
    res                  = '0;

    if (restart) begin
      phase_next           = PH_HUNT;
      magic_window_next    = '0;
      window_fill_next     = '0;
      header_count_next    = '0;
      bytes_remaining_next = '0;
      header_version_next  = '0;
      header_type_next     = '0;
      header_sequence_next = '0;
      header_length_next   = '0;
      desync_flag_next     = 1'b0;
    end else begin
      unique case (phase)
        PH_HEADER: begin
          unique case (header_count)
            4'd4:    header_version_next = rx_byte;
            4'd5:    header_type_next = rx_byte;
            4'd6:    header_sequence_next = {8'd0, rx_byte};
            4'd7:    header_sequence_next[15:8] = rx_byte;
            4'd8:    header_length_next = {24'd0, rx_byte};
            4'd9:    header_length_next[15:8] = rx_byte;
            4'd10:   header_length_next[23:16] = rx_byte;
            default: header_length_next[31:24] = rx_byte;
          endcase
          header_count_next = header_count + 4'd1;
          if (header_count_next == 4'd12) begin
            emit               = 1'b1;
            res.frame_type     = header_type_next;
            res.sequence_res   = header_sequence_next;
            res.last           = 1'b1;
            if (header_version_next != cfg.protocol_version) begin
              res.kind       = mhfd_pkg::KIND_ERROR;
              res.error_code = mhfd_pkg::ERR_BAD_VERSION;
            end else if (header_length_next > {16'd0, cfg.max_payload}) begin
              res.kind       = mhfd_pkg::KIND_ERROR;
              res.error_code = mhfd_pkg::ERR_PAYLOAD_TOO_LARGE;
            end else begin
              res.kind           = mhfd_pkg::KIND_HEADER;
              res.error_code     = mhfd_pkg::ERR_NONE;
              res.payload_length = header_length_next[15:0];
              res.last           = (header_length_next == 32'd0);
            end
            if (res.kind == mhfd_pkg::KIND_HEADER && !res.last) begin
              phase_next           = PH_PAYLOAD;
              bytes_remaining_next = header_length_next[15:0];
              header_count_next    = '0;
            end else begin
              phase_next           = PH_HUNT;
              magic_window_next    = '0;
              window_fill_next     = '0;
              header_count_next    = '0;
              bytes_remaining_next = '0;
            end
          end
        end
        PH_PAYLOAD: begin
          emit               = 1'b1;
          res.kind           = mhfd_pkg::KIND_PAYLOAD;
          res.frame_type     = header_type;
          res.sequence_res   = header_sequence;
          res.payload_length = header_length[15:0];
          res.data_byte      = rx_byte;
          res.error_code     = mhfd_pkg::ERR_NONE;
          res.last           = (bytes_remaining <= 16'd1);
          if (res.last) begin
            phase_next           = PH_HUNT;
            magic_window_next    = '0;
            window_fill_next     = '0;
            header_count_next    = '0;
            bytes_remaining_next = '0;
          end else begin
            bytes_remaining_next = bytes_remaining - 16'd1;
          end
        end
        default: begin
          magic_window_next = {magic_window[23:0], rx_byte};
          window_fill_next  = (window_fill == 3'd4) ? 3'd4 : window_fill + 3'd1;
          if (window_fill_next == 3'd4) begin
            if (magic_window_next == cfg.magic_word) begin
              phase_next           = PH_HEADER;
              header_count_next    = 4'd4;
              header_version_next  = '0;
              header_type_next     = '0;
              header_sequence_next = '0;
              header_length_next   = '0;
              desync_flag_next     = 1'b0;
            end else if (!desync_flag) begin
              desync_flag_next = 1'b1;
              emit             = 1'b1;
              res.kind         = mhfd_pkg::KIND_ERROR;
              res.error_code   = mhfd_pkg::ERR_BAD_MAGIC;
              res.last         = 1'b1;
            end
          end
        end
      endcase
    end
  end

  assign res_valid = take && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      magic_window    <= '0;
      window_fill     <= '0;
      header_count    <= '0;
      header_version  <= '0;
      header_type     <= '0;
      header_sequence <= '0;
      header_length   <= '0;
      bytes_remaining <= '0;
      desync_flag     <= 1'b0;
    end else if (take) begin
      phase           <= phase_next;
      magic_window    <= magic_window_next;
      window_fill     <= window_fill_next;
      header_count    <= header_count_next;
      header_version  <= header_version_next;
      header_type     <= header_type_next;
      header_sequence <= header_sequence_next;
      header_length   <= header_length_next;
      bytes_remaining <= bytes_remaining_next;
      desync_flag     <= desync_flag_next;
    end
  end

  a_payload_remaining: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> bytes_remaining != 16'd0)
    else $error("payload phase with no bytes remaining");

  a_header_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> (header_count >= 4'd4 && header_count <= 4'd11))
    else $error("header count out of range");

  a_window_fill: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_HUNT) |-> (window_fill == 3'd4))
    else $error("left hunting without a full window");

endmodule

[rtl/mhfd_obuf.sv]
module mhfd_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mhfd_pkg::result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output mhfd_pkg::result_t out_data
);

  mhfd_pkg::result_t entry0, entry1;
  logic [1:0]        count;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign space     = (count != 2'd2);
  assign out_data  = entry0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd1) begin
        entry0 <= push_data;
      end else begin
        entry0 <= entry1;
        entry1 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        entry0 <= push_data;
      end else begin
        entry1 <= push_data;
      end
    end else if (pop) begin
      entry0 <= entry1;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("output buffer count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != 2'd2)
    else $error("push into a full output buffer");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1)
    else $error("output buffer count did not advance on push");

endmodule

[tb/magic_header_frame_deframer_core_tb.sv]
module magic_header_frame_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200_000;

  typedef enum logic [1:0] {HUNTING, IN_HEADER, IN_PAYLOAD} parse_phase_t;

  typedef struct packed {
    logic       restart;
    logic [7:0] value;
  } stream_word_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [7:0]                     rx_byte = 8'd0;
  logic                           restart = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [1:0]                     kind;
  logic [7:0]                     frame_type;
  logic [15:0]                    sequence_res;
  logic [15:0]                    payload_length;
  logic [7:0]                     data_byte;
  logic [1:0]                     error_code;
  logic                           last;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [mhfd_pkg::AddrWidth-1:0] paddr = '0;
  logic [mhfd_pkg::DataWidth-1:0] pwdata = '0;
  logic [mhfd_pkg::DataWidth-1:0] prdata;
  logic                           pready;

  magic_header_frame_deframer_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .restart(restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .frame_type(frame_type),
    .sequence_res(sequence_res),
    .payload_length(payload_length),
    .data_byte(data_byte),
    .error_code(error_code),
    .last(last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  stream_word_t       stream_q[$];
  stream_word_t       next_word;
  mhfd_pkg::result_t  due_results[$];
  bit                 idle_on = 1'b1;
  int unsigned        gap_left = 0;
  int unsigned        stall_left = 0;
  int unsigned        mismatches = 0;
  int unsigned        cycle_count = 0;

  mhfd_pkg::cfg_t cfg = '{mhfd_pkg::MAGIC_WORD_RESET, mhfd_pkg::VERSION_RESET,
                          mhfd_pkg::MAX_PAYLOAD_RESET};
  logic [31:0]  win = '0;
  int unsigned  win_fill = 0;
  parse_phase_t ph = HUNTING;
  int unsigned  hdr_count = 0;
  logic [7:0]   hdr_ver = '0;
  logic [7:0]   hdr_type = '0;
  logic [15:0]  hdr_seq = '0;
  logic [31:0]  hdr_len = '0;
  logic [15:0]  remaining = '0;
  logic         desynced = 1'b0;

  function automatic void clear_parse();
    win = '0;
    win_fill = 0;
    ph = HUNTING;
    hdr_count = 0;
    remaining = '0;
  endfunction

  function automatic void clear_header();
    hdr_ver = '0;
    hdr_type = '0;
    hdr_seq = '0;
    hdr_len = '0;
  endfunction

  function automatic void deframe_word(input logic [7:0] b, input logic rs,
                                       output bit produced, output mhfd_pkg::result_t r);
    produced = 1'b0;
    r = '0;
    if (rs) begin
      clear_parse();
      clear_header();
      desynced = 1'b0;
    end else begin
      case (ph)
        IN_HEADER: begin
          case (hdr_count)
            4: hdr_ver = b;
            5: hdr_type = b;
            6: hdr_seq[7:0] = b;
            7: hdr_seq[15:8] = b;
            8: hdr_len[7:0] = b;
            9: hdr_len[15:8] = b;
            10: hdr_len[23:16] = b;
            default: hdr_len[31:24] = b;
          endcase
          hdr_count++;
          if (hdr_count == 12) begin
            produced = 1'b1;
            r.frame_type = hdr_type;
            r.sequence_res = hdr_seq;
            r.last = 1'b1;
            if (hdr_ver != cfg.protocol_version) begin
              r.kind = mhfd_pkg::KIND_ERROR;
              r.error_code = mhfd_pkg::ERR_BAD_VERSION;
              clear_parse();
            end else if (hdr_len > {16'd0, cfg.max_payload}) begin
              r.kind = mhfd_pkg::KIND_ERROR;
              r.error_code = mhfd_pkg::ERR_PAYLOAD_TOO_LARGE;
              clear_parse();
            end else begin
              r.kind = mhfd_pkg::KIND_HEADER;
              r.error_code = mhfd_pkg::ERR_NONE;
              r.payload_length = hdr_len[15:0];
              r.last = (hdr_len == 0);
              if (hdr_len == 0) begin
                clear_parse();
              end else begin
                ph = IN_PAYLOAD;
                remaining = hdr_len[15:0];
                hdr_count = 0;
              end
            end
          end
        end
        IN_PAYLOAD: begin
          produced = 1'b1;
          r.kind = mhfd_pkg::KIND_PAYLOAD;
          r.frame_type = hdr_type;
          r.sequence_res = hdr_seq;
          r.payload_length = hdr_len[15:0];
          r.data_byte = b;
          r.error_code = mhfd_pkg::ERR_NONE;
          r.last = (remaining <= 1);
          if (remaining <= 1) begin
            clear_parse();
          end else begin
            remaining--;
          end
        end
        default: begin
          win = {win[23:0], b};
          if (win_fill < 4) begin
            win_fill++;
          end
          if (win_fill == 4) begin
            if (win == cfg.magic_word) begin
              ph = IN_HEADER;
              hdr_count = 4;
              clear_header();
              desynced = 1'b0;
            end else if (!desynced) begin
              desynced = 1'b1;
              produced = 1'b1;
              r.kind = mhfd_pkg::KIND_ERROR;
              r.error_code = mhfd_pkg::ERR_BAD_MAGIC;
              r.last = 1'b1;
            end
          end
        end
      endcase
    end
  endfunction

  function automatic void report_mismatch(string what, mhfd_pkg::result_t want,
                                          mhfd_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected kind=%0d type=%h seq=%h len=%0d data=%h err=%0d last=%b",
               what, want.kind, want.frame_type, want.sequence_res, want.payload_length,
               want.data_byte, want.error_code, want.last);
      $display("  actual kind=%0d type=%h seq=%h len=%0d data=%h err=%0d last=%b",
               got.kind, got.frame_type, got.sequence_res, got.payload_length,
               got.data_byte, got.error_code, got.last);
    end
  endfunction

  function automatic void push_word(input logic rs, input logic [7:0] v);
    stream_q.push_back({rs, v});
  endfunction

  // A frame of random content built from the current register values, with an
  // occasional noise prefix, wrong version, oversized length or cut by a restart.
  function automatic void queue_frame();
    logic [7:0]  fb[$];
    logic [7:0]  ver;
    logic [31:0] len;
    int unsigned cap;
    int unsigned r;
    int unsigned cut;
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 2)) fb.push_back(8'($urandom));
    end
    for (int i = 3; i >= 0; i--) fb.push_back(cfg.magic_word[8*i +: 8]);
    ver = cfg.protocol_version;
    if ($urandom_range(0, 11) == 0) begin
      ver = ver ^ 8'($urandom_range(1, 255));
    end
    cap = (cfg.max_payload < 24) ? cfg.max_payload : 24;
    if ($urandom_range(0, 14) == 0) begin
      cap = (cfg.max_payload < 300) ? cfg.max_payload : 300;
    end
    r = $urandom_range(0, 19);
    if (r == 2) begin
      len = {16'd0, cfg.max_payload} + 32'd1 + 32'($urandom_range(0, 3));
    end else if (r == 3) begin
      len = $urandom | 32'h0001_0000;
    end else if (r < 2 || cap == 0) begin
      len = '0;
    end else begin
      len = $urandom_range(1, cap);
    end
    fb.push_back(ver);
    fb.push_back(8'($urandom));
    fb.push_back(8'($urandom));
    fb.push_back(8'($urandom));
    for (int i = 0; i < 4; i++) fb.push_back(len[8*i +: 8]);
    if (ver == cfg.protocol_version && len <= {16'd0, cfg.max_payload}) begin
      for (int unsigned i = 0; i < len; i++) fb.push_back(8'($urandom));
    end
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, fb.size() - 1) : fb.size();
    for (int i = 0; i < cut; i++) push_word(1'b0, fb[i]);
    if (cut < fb.size()) begin
      push_word(1'b1, 8'($urandom));
    end
  endfunction

  function automatic void queue_traffic(input int unsigned n_words);
    int unsigned target;
    int unsigned r;
    target = stream_q.size() + n_words;
    while (stream_q.size() < target) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        queue_frame();
      end else if (r < 9) begin
        repeat ($urandom_range(1, 8)) push_word(1'b0, 8'($urandom));
      end else begin
        push_word(1'b1, 8'($urandom));
      end
    end
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      mhfd_pkg::REG_MAGIC_WORD: cfg.magic_word = val;
      mhfd_pkg::REG_VERSION: cfg.protocol_version = val[7:0];
      default: cfg.max_payload = val[15:0];
    endcase
  endtask

  task automatic set_config(input logic [31:0] magic, input logic [7:0] ver,
                            input logic [15:0] max_len);
    write_reg(mhfd_pkg::REG_MAGIC_WORD, magic);
    write_reg(mhfd_pkg::REG_VERSION, {24'd0, ver});
    write_reg(mhfd_pkg::REG_MAX_PAYLOAD, {16'd0, max_len});
  endtask

  task automatic drain();
    while (stream_q.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (stream_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(1, 8) - 1;
        in_valid <= 1'b0;
      end else begin
        next_word = stream_q.pop_front();
        in_valid <= 1'b1;
        rx_byte <= next_word.value;
        restart <= next_word.restart;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch_words
    mhfd_pkg::result_t got;
    mhfd_pkg::result_t want;
    mhfd_pkg::result_t r;
    bit                made;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = {kind, frame_type, sequence_res, payload_length, data_byte, error_code, last};
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind || got.frame_type !== want.frame_type ||
              got.sequence_res !== want.sequence_res ||
              got.payload_length !== want.payload_length ||
              got.data_byte !== want.data_byte || got.error_code !== want.error_code ||
              got.last !== want.last) begin
            report_mismatch("result mismatch", want, got);
          end
        end
      end
      if (in_valid && in_ready) begin
        deframe_word(rx_byte, restart, made, r);
        if (made) begin
          due_results.push_back(r);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    push_word(1'b1, 8'hFF);
    for (int i = 0; i < 4; i++) push_word(1'b0, 8'h00);
    push_word(1'b0, 8'h01);
    push_word(1'b0, 8'hFF);
    push_word(1'b0, 8'hFF);
    push_word(1'b0, 8'hFF);
    for (int i = 0; i < 4; i++) push_word(1'b0, 8'h00);
    for (int i = 0; i < 4; i++) push_word(1'b0, 8'h00);
    push_word(1'b0, 8'h02);
    push_word(1'b0, 8'h00);
    push_word(1'b0, 8'h00);
    push_word(1'b0, 8'h00);
    push_word(1'b0, 8'h05);
    for (int i = 0; i < 3; i++) push_word(1'b0, 8'h00);
    push_word(1'b0, 8'h80);
    push_word(1'b0, 8'h7F);
    push_word(1'b0, 8'h01);
    push_word(1'b0, 8'h02);
    push_word(1'b0, 8'h03);
    drain();

    set_config($urandom, 8'($urandom), 16'd40);
    queue_traffic(160);
    drain();
    set_config(32'hFFFF_FFFF, 8'hFF, 16'd0);
    queue_traffic(150);
    drain();
    set_config(32'h0000_0000, 8'h00, 16'hFFFF);
    queue_traffic(160);
    drain();
    set_config($urandom, 8'($urandom), 16'($urandom_range(1, 300)));
    queue_traffic(160);
    drain();
    set_config($urandom & 32'hFF00_FF00, 8'h01, 16'd7);
    queue_traffic(150);
    drain();

    idle_on = 1'b0;
    set_config($urandom, 8'($urandom), mhfd_pkg::MAX_PAYLOAD_RESET);
    queue_traffic(150);
    drain();

    while (due_results.size() != 0) begin
      report_mismatch("result never arrived", due_results.pop_front(), '0);
    end
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
